// ===== src/stkil_pkg.sv =====
package stkil_pkg;

	// Storage and field geometry.
	localparam int MAX_ENTRIES = 64;
	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_W       = 6;
	localparam int CAP_W       = 7;
	localparam int STORED_W    = 7;
	localparam int OP_W        = 2;

	// One spare row holds the entry pushed past the end before eviction.
	localparam int ADDR_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_W = KEY_BITS + HANDLE_BITS;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_RAW_W  = KEY_BITS + HANDLE_BITS + IDX_W;
	localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W = KEY_BITS + 2 * HANDLE_BITS + 2 + STORED_W;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic shift;
		logic place_mid;
		logic place_zero;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  in_op;
		logic count_zero;
		logic key_ge;
		logic ptr_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ===== src/stkil_ctrl.sv =====
module stkil_ctrl
	import stkil_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_PLACE  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (status.in_op == OP_INSERT) begin
						state_d = status.count_zero ? ST_PLACE : ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				// Walk down from the tail, moving each larger-or-equal entry up one row.
				if (status.key_ge) begin
					cmd.shift = 1'b1;
					if (status.ptr_zero) begin
						state_d = ST_PLACE;
					end
				end else begin
					cmd.place_mid = 1'b1;
					state_d       = ST_FINISH;
				end
			end
			ST_PLACE: begin
				cmd.place_zero = 1'b1;
				state_d        = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/stkil_datapath.sv =====
module stkil_datapath
	import stkil_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic [OP_W-1:0]  s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status
);

	// Entry store, with one spare row above the largest capacity.
	logic [ENTRY_W-1:0] mem [0:MAX_ENTRIES];

	logic [CAP_W-1:0]       cap_q;
	logic [CNT_W-1:0]       count_q;
	op_t                    op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [IDX_W-1:0]       idx_q;
	logic [ADDR_W-1:0]      ptr_q;
	logic                   first_q;
	logic [HANDLE_BITS-1:0] last_handle_q;
	logic [ENTRY_W-1:0]     rd_entry_q;

	logic [KEY_BITS-1:0]    res_key_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic                   res_hit_q;
	logic                   res_ev_q;
	logic [HANDLE_BITS-1:0] res_ev_handle_q;
	logic [STORED_W-1:0]    res_count_q;

	logic [KEY_BITS-1:0]    in_key;
	logic [HANDLE_BITS-1:0] in_handle;
	logic [IDX_W-1:0]       in_idx;
	op_t                    in_op;

	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [ENTRY_W-1:0]     wr_data;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [KEY_BITS-1:0]    rd_key;
	logic [CNT_W-1:0]       cap_eff;
	logic [CNT_W:0]         count_inc;
	logic                   over_cap;
	logic                   read_hit;
	logic                   do_hit;
	logic                   do_evict;
	logic [CNT_W-1:0]       count_next;

	// Unpack the input beat.
	assign in_key    = s_tdata[KEY_BITS-1:0];
	assign in_handle = s_tdata[KEY_BITS +: HANDLE_BITS];
	assign in_idx    = s_tdata[KEY_BITS + HANDLE_BITS +: IDX_W];
	assign in_op     = op_t'(s_tuser);

	assign rd_key = rd_entry_q[ENTRY_W-1 -: KEY_BITS];

	// Capacity is clamped to the range the store can hold.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			cap_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);
	assign over_cap  = count_inc > {1'b0, cap_eff};
	assign read_hit  = CNT_W'(idx_q) < count_q;
	assign do_hit    = (op_q == OP_READ) && read_hit;
	assign do_evict  = (op_q == OP_INSERT) && over_cap;

	// Count after the current item: inserts grow up to the capacity, a clear empties.
	assign count_next = (op_q == OP_INSERT) ? (over_cap ? cap_eff : count_inc[CNT_W-1:0]) :
		(op_q == OP_CLEAR) ? '0 : count_q;

	// Memory write port: shifted entries move up a row, the new entry lands in the gap.
	always_comb begin
		wr_en   = cmd.shift | cmd.place_mid | cmd.place_zero;
		wr_addr = cmd.place_zero ? '0 : ptr_q + ADDR_W'(1);
		wr_data = cmd.shift ? rd_entry_q : {key_q, handle_q};
	end

	// Memory read port: the tail or the requested row on accept, then the next row down.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q - ADDR_W'(1);
		if (cmd.load) begin
			if (in_op == OP_READ) begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(in_idx);
			end else if (in_op == OP_INSERT && count_q != '0) begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(count_q - CNT_W'(1));
			end
		end else if (cmd.shift && ptr_q != '0) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	// Latched item fields and the scan pointer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			key_q    <= in_key;
			handle_q <= in_handle;
			idx_q    <= in_idx;
			ptr_q    <= ADDR_W'(count_q - CNT_W'(1));
		end else if (cmd.shift) begin
			ptr_q <= ptr_q - ADDR_W'(1);
		end
		if (wr_en && first_q) begin
			last_handle_q <= wr_data[HANDLE_BITS-1:0];
		end
	end

	// The first write of an insert goes to the tail row; its handle is the eviction candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (cmd.load) begin
			first_q <= 1'b1;
		end else if (wr_en) begin
			first_q <= 1'b0;
		end
	end

	// Capacity register and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.finish) begin
				count_q <= count_next;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Result register; read fields only on a read hit, eviction fields only on an insert.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_key_q       <= do_hit ? rd_key : '0;
			res_handle_q    <= do_hit ? rd_entry_q[HANDLE_BITS-1:0] : '0;
			res_hit_q       <= do_hit;
			res_ev_q        <= do_evict;
			res_ev_handle_q <= do_evict ? last_handle_q : '0;
			res_count_q     <= STORED_W'(count_next);
		end
	end

	assign m_tdata = {(OUT_W - OUT_RAW_W)'(0), res_count_q, res_ev_handle_q, res_ev_q,
		res_hit_q, res_handle_q, res_key_q};

	// Status back to the controller.
	always_comb begin
		status.in_op      = in_op;
		status.count_zero = count_q == '0;
		status.key_ge     = $signed(rd_key) >= $signed(key_q);
		status.ptr_zero   = ptr_q == '0;
		status.out_free   = !m_tvalid || m_tready;
	end

endmodule

// ===== src/sorted_top_k_insert_list_core.sv =====
// Read, clear and idle opcodes go from idle to the finish state, which registers the result.
// An insert shifts up each stored entry whose key is not below the new key, then places it.
// A new item is accepted only after the current one has finished.
// Reset (arst_n low, asynchronous) empties the list and sets capacity to 64.
// Entry memory contents are not cleared; rows at or above the count are never returned.
module sorted_top_k_insert_list_core
	import stkil_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// Fields from bit 0: new_key[31:0], new_handle[47:32], read_index[53:48], zero pad.
	input  logic [IN_W-1:0]  s_tdata,
	// Fields from bit 0: opcode[1:0].
	input  logic [OP_W-1:0]  s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// Fields from bit 0: result_key[31:0], result_handle[47:32], result_hit[48],
	// evicted[49], evicted_handle[65:50], stored_count[72:66], zero pad.
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	stkil_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	stkil_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

// ===== src/stkil_checker.sv =====
module stkil_checker
	import stkil_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic                hit;
	logic                ev;
	logic [STORED_W-1:0] cnt;

	assign hit = m_tdata[KEY_BITS + HANDLE_BITS];
	assign ev  = m_tdata[KEY_BITS + HANDLE_BITS + 1];
	assign cnt = m_tdata[KEY_BITS + 2 * HANDLE_BITS + 2 +: STORED_W];

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// One item at a time: the input side closes right after a beat is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// A hit and an eviction never come from the same item.
	a_hit_or_ev: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(hit && ev))
		else $error("read hit and eviction in one result");

	// A hit or an eviction leaves a nonempty list within the store depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (hit || ev) |-> cnt != '0 && int'(cnt) <= MAX_ENTRIES)
		else $error("stored count inconsistent with result");

endmodule

bind sorted_top_k_insert_list_core stkil_checker u_stkil_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
